[design/ssort_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types and constants of the sign split sorter.
// ----------------------------------------------------------------------------
package ssort_pkg;

	localparam int VALUE_W = 32;
	localparam int MODE_W  = 3;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		value_t value_in;
		logic   last_item;
	} in_item_t;

	typedef struct packed {
		value_t value_out;
		logic   last_out;
	} out_item_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} chain_ctrl_t;

	localparam logic [MODE_W-1:0] MODE_NEG_ASC  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NEG_DESC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POS_ASC  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POS_DESC = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PATTERN  = 3'd4;

endpackage : ssort_pkg
`default_nettype wire

[design/ssort_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssort_cell
// One slot of the insertion chain. An empty slot compares as greater than any
// value, so the occupied slots always stay sorted ascending from the head.
// ----------------------------------------------------------------------------
module ssort_cell
	import ssort_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire chain_ctrl_t ctrl,
	input  wire value_t      ins_value,
	input  wire logic        left_valid,
	input  wire value_t      left_value,
	input  wire logic        left_gt,
	input  wire logic        right_valid,
	input  wire value_t      right_value,
	output logic             valid,
	output value_t           value,
	output logic             gt
);

	logic   valid_q;
	value_t value_q;

	assign gt    = !valid_q || (value_q > ins_value);
	assign valid = valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (gt) begin
				valid_q <= left_gt ? left_valid : 1'b1;
			end
		end else if (ctrl.drain) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (gt) begin
				value_q <= left_gt ? left_value : ins_value;
			end
		end else if (ctrl.drain) begin
			value_q <= right_value;
		end
	end

endmodule : ssort_cell
`default_nettype wire

[design/ssort_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssort_chain
// A row of sorting cells. Inserts one value per cycle in order, and drains
// the sorted contents out of the head one value per cycle.
// ----------------------------------------------------------------------------
module ssort_chain
	import ssort_pkg::*;
#(
	parameter int NUM_CELLS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire chain_ctrl_t ctrl,
	input  wire value_t      ins_value,
	output value_t           head_value
);

	logic   cell_valid [NUM_CELLS];
	value_t cell_value [NUM_CELLS];
	logic   cell_gt    [NUM_CELLS];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic   l_valid;
		value_t l_value;
		logic   l_gt;
		logic   r_valid;
		value_t r_value;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_value = '0;
			assign l_gt    = 1'b0;
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_value = cell_value[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == NUM_CELLS - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_value = '0;
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
		end

		ssort_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.ins_value   (ins_value),
			.left_valid  (l_valid),
			.left_value  (l_value),
			.left_gt     (l_gt),
			.right_valid (r_valid),
			.right_value (r_value),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	assign head_value = cell_value[0];

endmodule : ssort_chain
`default_nettype wire

[design/sign_split_sorter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sign_split_sorter_core
// Collects a set of signed words in a sorting chain and emits the set
// reordered by sign groups as the order mode selects.
// ----------------------------------------------------------------------------
// Channel   Signals                 Direction  Transaction
// input     start, busy, item       in         start high while busy is low
// result    result_valid, result    out        every cycle result_valid is high
// config    cfg_we, cfg_data        in         every cycle cfg_we is high
//
// Items load into the chain one at a time. After the last item of a set the
// chain drains into the sort buffer, and the buffer then streams the n
// results one per cycle through the s1 and s2 read stages; busy stays
// high until the last result. Reset empties the chain at once; the buffers
// need no clearing. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module sign_split_sorter_core
	import ssort_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire in_item_t          item,
	input  wire logic              cfg_we,
	input  wire logic [MODE_W-1:0] cfg_data,
	output logic                   result_valid,
	output out_item_t              result
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam logic [CW-1:0] ONE        = CW'(1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [MODE_W-1:0] mode_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     neg_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     len_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     p0_q;
	logic [AW-1:0]     p1_q;
	logic              up0_q;
	logic              up1_q;
	logic              valid_s1;
	logic              valid_s2;
	logic [CW-1:0]     k_s1;
	logic              sgn_s1;
	logic              last_s2;
	value_t            rd_q;

	value_t            value_mem [MAX_ITEMS];
	logic              sign_mem  [MAX_ITEMS];

	chain_ctrl_t       ctrl;
	value_t            head_value;
	logic              accept;
	logic [CW-1:0]     cnt_next;
	logic              set_end;
	logic              drain_end;
	logic              issue;
	logic              sel_hi;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     n_m1;
	logic [CW-1:0]     neg_m1;
	logic [CW-1:0]     n_pos;
	logic [CW-1:0]     n_pos_m1;
	logic [AW-1:0]     init_p0;
	logic [AW-1:0]     init_p1;
	logic              init_up0;
	logic              init_up1;
	logic [CW-1:0]     init_len;

	assign accept    = start && (state_q == ST_LOAD);
	assign busy      = (state_q != ST_LOAD);
	assign cnt_next  = cnt_q + ONE;
	assign set_end   = item.last_item || (cnt_next == FULL_COUNT);
	assign n_m1      = n_q - ONE;
	assign drain_end = (CW'(j_q) == n_m1);
	assign issue     = (state_q == ST_EMIT) && (k_q != n_q);
	assign sel_hi    = (mode_q == MODE_PATTERN) ? sgn_s1 : (k_s1 >= len_q);
	assign rd_addr   = sel_hi ? p1_q : p0_q;

	assign ctrl.insert = accept;
	assign ctrl.drain  = (state_q == ST_DRAIN);

	assign neg_m1   = neg_q - ONE;
	assign n_pos    = n_q - pos_q;
	assign n_pos_m1 = n_pos - ONE;

	always_comb begin
		unique case (mode_q)
			MODE_NEG_DESC: begin
				init_p0  = AW'(neg_m1);
				init_up0 = 1'b0;
				init_p1  = AW'(neg_q);
				init_up1 = 1'b1;
				init_len = neg_q;
			end
			MODE_POS_ASC: begin
				init_p0  = AW'(n_pos);
				init_up0 = 1'b1;
				init_p1  = AW'(n_pos_m1);
				init_up1 = 1'b0;
				init_len = pos_q;
			end
			MODE_POS_DESC: begin
				init_p0  = AW'(n_m1);
				init_up0 = 1'b0;
				init_p1  = '0;
				init_up1 = 1'b1;
				init_len = pos_q;
			end
			default: begin
				init_p0  = '0;
				init_up0 = 1'b1;
				init_p1  = AW'(n_m1);
				init_up1 = 1'b0;
				init_len = neg_q;
			end
		endcase
	end

	ssort_chain #(
		.NUM_CELLS (MAX_ITEMS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.ins_value  (item.value_in),
		.head_value (head_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			mode_q   <= MODE_NEG_ASC;
			cnt_q    <= '0;
			neg_q    <= '0;
			pos_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			len_q    <= '0;
			j_q      <= '0;
			p0_q     <= '0;
			p1_q     <= '0;
			up0_q    <= 1'b0;
			up1_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			last_s2  <= (k_s1 == n_m1);
			if (valid_s1) begin
				if (sel_hi) begin
					p1_q <= up1_q ? p1_q + AW'(1) : p1_q - AW'(1);
				end else begin
					p0_q <= up0_q ? p0_q + AW'(1) : p0_q - AW'(1);
				end
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_next;
						if (item.value_in[VALUE_W-1]) begin
							neg_q <= neg_q + ONE;
						end else if (item.value_in != '0) begin
							pos_q <= pos_q + ONE;
						end
						if (set_end) begin
							state_q <= ST_DRAIN;
							n_q     <= cnt_next;
							j_q     <= '0;
						end
					end
				end
				ST_DRAIN: begin
					j_q <= j_q + AW'(1);
					if (drain_end) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
						p0_q    <= init_p0;
						p1_q    <= init_p1;
						up0_q   <= init_up0;
						up1_q   <= init_up1;
						len_q   <= init_len;
						cnt_q   <= '0;
						neg_q   <= '0;
						pos_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						k_q <= k_q + ONE;
					end
					if (valid_s2 && last_s2) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sign_mem[cnt_q[AW-1:0]] <= !item.value_in[VALUE_W-1];
		end
		if (ctrl.drain) begin
			value_mem[j_q] <= head_value;
		end
		sgn_s1 <= sign_mem[k_q[AW-1:0]];
		k_s1   <= k_q;
		if (valid_s1) begin
			rd_q <= value_mem[rd_addr];
		end
	end

	assign result_valid     = valid_s2;
	assign result.value_out = rd_q;
	assign result.last_out  = last_s2;

endmodule : sign_split_sorter_core
`default_nettype wire

[bench/sign_split_sorter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_split_sorter_core_tb
// Loads sets of signed words into the sorter under every order mode and
// checks each emitted word and its last flag against an in-bench prediction
// of the sign-group ordering, with random gaps between input transactions.
// ----------------------------------------------------------------------------
module sign_split_sorter_core_tb;
	import ssort_pkg::*;

	localparam int SET_CAP     = 64;
	localparam int RAND_ITEMS  = 400;
	localparam int PHASE_ITEMS = 36;
	localparam int CYCLE_LIMIT = 200000;
	localparam value_t VAL_MIN = 32'sh8000_0000;
	localparam value_t VAL_MAX = 32'sh7fff_ffff;

	class sort_scoreboard;
		value_t              loaded[SET_CAP];
		value_t              ranked[SET_CAP];
		int                  loaded_count;
		int                  emit_idx;
		logic [MODE_W-1:0]   order;
		out_item_t           sorted_out[$];
		int                  fails;

		function new();
			loaded_count = 0;
			emit_idx = 0;
			order = MODE_NEG_ASC;
			fails = 0;
		endfunction

		function void set_order(logic [MODE_W-1:0] m);
			order = m;
		endfunction

		function void push_word(value_t v, int n);
			out_item_t r;
			r.value_out = v;
			r.last_out = (emit_idx == n - 1);
			sorted_out.push_back(r);
			emit_idx++;
		endfunction

		function void push_span(int from, int to, int n);
			int stride;
			int p;
			if (from < 0 || to < 0 || from >= n || to >= n)
				return;
			stride = (from <= to) ? 1 : -1;
			p = from - stride;
			do begin
				p += stride;
				push_word(ranked[p], n);
			end while (p != to);
		endfunction

		function void note_item(in_item_t it);
			int n;
			int i;
			int j;
			int neg;
			int pos;
			int lo;
			int hi;
			value_t v;
			if (loaded_count >= SET_CAP)
				loaded_count = 0;
			loaded[loaded_count] = it.value_in;
			loaded_count++;
			if (!it.last_item && loaded_count < SET_CAP)
				return;
			n = loaded_count;
			loaded_count = 0;
			neg = 0;
			pos = 0;
			for (i = 0; i < n; i++) begin
				v = loaded[i];
				j = i;
				while (j > 0 && ranked[j - 1] > v) begin
					ranked[j] = ranked[j - 1];
					j--;
				end
				ranked[j] = v;
				if (v < 0)
					neg++;
				else if (v > 0)
					pos++;
			end
			emit_idx = 0;
			case (order)
				MODE_NEG_DESC: begin
					push_span(neg - 1, 0, n);
					push_span(neg, n - 1, n);
				end
				MODE_POS_ASC: begin
					push_span(n - pos, n - 1, n);
					push_span(n - pos - 1, 0, n);
				end
				MODE_POS_DESC: begin
					push_span(n - 1, n - pos, n);
					push_span(0, n - pos - 1, n);
				end
				MODE_PATTERN: begin
					lo = 0;
					hi = n - 1;
					for (i = 0; i < n; i++) begin
						if (loaded[i] >= 0) begin
							push_word(ranked[hi], n);
							hi--;
						end else begin
							push_word(ranked[lo], n);
							lo++;
						end
					end
				end
				default: begin
					push_span(0, neg - 1, n);
					push_span(n - 1, neg, n);
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (sorted_out.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: value %0d last %0b",
						got.value_out, got.last_out);
				return;
			end
			want = sorted_out.pop_front();
			if (got.value_out !== want.value_out || got.last_out !== want.last_out) begin
				fails++;
				if (fails <= 10)
					$display("mismatch: expected value %0d last %0b, got value %0d last %0b",
						want.value_out, want.last_out, got.value_out, got.last_out);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          item;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_data;
	logic              result_valid;
	out_item_t         result;

	sort_scoreboard    sb;
	int                cycles = 0;
	int                sent_random = 0;

	sign_split_sorter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	task automatic send_item(input value_t v, input logic last, input int gap);
		in_item_t it;
		it.value_in = v;
		it.last_item = last;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic wait_results();
		start <= 1'b0;
		while (sb.sorted_out.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_order(input logic [MODE_W-1:0] m);
		wait_results();
		while (busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_order(m);
	endtask

	function automatic value_t rand_value();
		value_t v;
		case ($urandom_range(0, 9))
			0: v = VAL_MIN;
			1: v = VAL_MAX;
			2: v = '0;
			3, 4, 5: begin
				v = $urandom_range(0, 14);
				v = v - 7;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_set(input int len);
		bit burst;
		int i;
		burst = ($urandom_range(0, 3) == 0);
		for (i = 0; i < len; i++)
			send_item(rand_value(), i == len - 1, burst ? 0 : $urandom_range(0, 10));
		sent_random += len;
	endtask

	initial begin
		logic [MODE_W-1:0] corner_modes[5];
		int m;
		int phase;
		int phase_count;
		int len;
		int pick;
		sb = new();
		corner_modes = '{MODE_NEG_ASC, MODE_NEG_DESC, MODE_POS_ASC, MODE_POS_DESC,
			MODE_PATTERN};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (m = 0; m < 5; m++) begin
			write_order(corner_modes[m]);
			send_item(VAL_MIN, 1'b0, 0);
			send_item('0, 1'b0, 1);
			send_item(VAL_MAX, 1'b1, 0);
		end
		write_order(MODE_POS_ASC);
		send_item('0, 1'b0, 0);
		send_item(-32'sd4, 1'b0, 0);
		send_item('0, 1'b1, 2);
		send_item(32'sd9, 1'b1, 0);
		write_order(MODE_NEG_ASC);
		send_item(-32'sd1, 1'b0, 0);
		send_item(-32'sd2, 1'b1, 0);

		phase = 0;
		while (sent_random < RAND_ITEMS) begin
			if (phase < 8)
				write_order(phase[MODE_W-1:0]);
			else
				write_order(MODE_W'($urandom_range(0, 7)));
			phase_count = sent_random;
			while (sent_random - phase_count < PHASE_ITEMS && sent_random < RAND_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					wait_results();
				pick = $urandom_range(0, 19);
				if (pick < 12)
					len = $urandom_range(1, 8);
				else if (pick < 17)
					len = $urandom_range(9, 24);
				else if (pick == 17)
					len = SET_CAP;
				else if (pick == 18)
					len = SET_CAP - 1;
				else
					len = $urandom_range(SET_CAP + 1, SET_CAP + 6);
				send_set(len);
			end
			phase++;
		end

		wait_results();
		repeat (20) @(negedge clk);
		sb.fails += sb.sorted_out.size();
		if (sb.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
